@@ sv/pps_pkg.sv @@
`default_nettype none

package pps_pkg;

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LA_MUL,
    ST_LA_DIV,
    ST_SQ_X,
    ST_SQ_Y,
    ST_LA_SQ,
    ST_GOAL,
    ST_FINISH,
    ST_SQRT,
    ST_MUL_VX,
    ST_MUL_VY,
    ST_NORM_INIT,
    ST_NORM,
    ST_CORDIC,
    ST_GAIN,
    ST_CLAMP,
    ST_SPD_MUL,
    ST_SPD_DIV,
    ST_SPD_DONE,
    ST_OUT
  } state_t;

  // result outcome codes
  typedef enum logic [2:0] {
    OC_DRIVE      = 3'd0,
    OC_SHORT_PATH = 3'd1,
    OC_NO_FORWARD = 3'd2,
    OC_AT_ORIGIN  = 3'd3,
    OC_TIMEOUT    = 3'd4
  } outcome_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_LA_MIN    = 3'd0,
    CFG_LA_MAX    = 3'd1,
    CFG_SPD_TGT   = 3'd2,
    CFG_SPD_MAX   = 3'd3,
    CFG_WHEELBASE = 3'd4,
    CFG_GAIN      = 3'd5,
    CFG_MAX_ANGLE = 3'd6,
    CFG_TIMEOUT   = 3'd7
  } cfg_idx_t;

  localparam int          CFG_DATA_W  = 16;
  localparam int          DIV_W       = 30;  // dividend width of the shared divider
  localparam int          DIVISOR_W   = 16;
  localparam int          GAIN_FRAC   = 12;
  localparam int          NORM_HI_BIT = 40;  // CORDIC input normalization target
  localparam int          NORM_FAST   = 36;  // below this, normalize four bits at once
  localparam int          FWD_LIMIT   = -51; // -0.05 m
  localparam logic [13:0] SPEED_FLOOR = 14'd307;
  localparam int          ATAN_DEPTH  = 24;

  // atan(2^-i) in units of 2^-30 rad
  localparam logic [31:0] ATAN_Q30 [0:ATAN_DEPTH-1] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516,  32'd16775851,  32'd8388437,   32'd4194283,   32'd2097149,
    32'd1048576,   32'd524288,    32'd262144,    32'd131072,    32'd65536,
    32'd32768,     32'd16384,     32'd8192,      32'd4096,      32'd2048,
    32'd1024,      32'd512,       32'd256,       32'd128
  };

endpackage

`default_nettype wire

@@ sv/pure_pursuit_steering_unit.sv @@
// Pure-pursuit steering unit with adaptive lookahead.
// Input channel (in_valid/in_ready) takes path points and 100 ms timer ticks.
// Points of one path arrive in order; in_last_point marks the final one.
// Result channel (out_valid/out_ready) carries steer, speed and outcome; a
// result follows the final point of each path and a tick past the timeout.
// Configuration writes (cfg_we/cfg_index/cfg_data) take effect at once and
// are expected only while the unit is idle.
// A tick is handled in the idle state. A path point passes the squaring and
// goal steps, plus, for the first point of a path with sound lookahead
// settings, a lookahead multiply and a 30-step divide. The final point adds
// a square root, normalization shifts, CORDIC and a speed divide; a stop
// skips these and goes straight to the output.
// One multiplier is shared by all multiply steps, one counter by all iterative steps.
// The unit takes no request while a path point is being processed.
// A finished result sits in the output register; a new request may still be
// accepted while the previous result is being taken, otherwise the unit
// waits until the output register is free.
// Reset (rst_n low, synchronous) restores the register defaults, clears
// the path state, the speed command and the idle tick count.
`default_nettype none

module pure_pursuit_steering_unit #(
  parameter int COORD_WIDTH     = 18,
  parameter int ANGLE_FRAC_BITS = 14,
  parameter int CORDIC_ITERS    = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_kind,
  input  wire logic signed [COORD_WIDTH-1:0] in_point_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_point_y,
  input  wire logic                          in_last_point,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [15:0]                 out_steer,
  output logic [13:0]                        out_speed,
  output logic [2:0]                         out_outcome,
  // configuration
  input  wire logic                          cfg_we,
  input  wire logic [2:0]                    cfg_index,
  input  wire logic [pps_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CW  = COORD_WIDTH;
  localparam int AF  = ANGLE_FRAC_BITS;
  localparam int MW0 = (CW > AF + 2) ? CW : AF + 2;
  localparam int MW  = (MW0 > 21) ? MW0 : 21;           // multiplier operand width
  localparam int PW  = 2 * MW;                          // product width
  localparam int SW  = 2 * CW;                          // squared magnitude width
  localparam int VW  = (CW + 15 > 41) ? CW + 15 : 41;   // CORDIC input magnitude
  localparam int XW  = VW + 3;                          // CORDIC x/y width
  localparam int ZW  = AF + 3;                          // CORDIC angle width
  localparam int RW  = CW + 1;                          // square root remainder
  localparam int DW  = pps_pkg::DIV_W;
  localparam int DVW = pps_pkg::DIVISOR_W;
  localparam int GAIN_SHIFT = pps_pkg::GAIN_FRAC;

  localparam logic signed [CW-1:0] FWD_LIMIT = CW'(pps_pkg::FWD_LIMIT);

  // ---------------------------------------------------------------------
  // configuration registers
  logic [14:0] la_min_r, la_max_r, max_ang_r;
  logic [13:0] spd_tgt_r, spd_max_r;
  logic [12:0] wb_r;
  logic [15:0] gain_r;
  logic [7:0]  tmo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      la_min_r  <= 15'd819;
      la_max_r  <= 15'd3072;
      spd_tgt_r <= 14'd1536;
      spd_max_r <= 14'd3072;
      wb_r      <= 13'd328;
      gain_r    <= 16'd4096;
      max_ang_r <= 15'd6554;
      tmo_r     <= 8'd5;
    end else if (cfg_we) begin
      unique case (pps_pkg::cfg_idx_t'(cfg_index))
        pps_pkg::CFG_LA_MIN:    la_min_r  <= cfg_data[14:0];
        pps_pkg::CFG_LA_MAX:    la_max_r  <= cfg_data[14:0];
        pps_pkg::CFG_SPD_TGT:   spd_tgt_r <= cfg_data[13:0];
        pps_pkg::CFG_SPD_MAX:   spd_max_r <= cfg_data[13:0];
        pps_pkg::CFG_WHEELBASE: wb_r      <= cfg_data[12:0];
        pps_pkg::CFG_GAIN:      gain_r    <= cfg_data;
        pps_pkg::CFG_MAX_ANGLE: max_ang_r <= cfg_data[14:0];
        pps_pkg::CFG_TIMEOUT:   tmo_r     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // registers
  pps_pkg::state_t state_r, state_nxt;

  logic [13:0]          spd_cmd_r, spd_cmd_nxt;
  logic [7:0]           idle_r, idle_nxt;
  logic                 in_msg_r, in_msg_nxt;
  logic [1:0]           pts_r, pts_nxt;
  logic [14:0]          la_r, la_nxt;
  logic signed [CW-1:0] gx_r, gx_nxt, gy_r, gy_nxt;
  logic [1:0]           gstat_r, gstat_nxt;
  logic [SW-1:0]        gmag_r, gmag_nxt;

  logic signed [CW-1:0] px_r, px_nxt, py_r, py_nxt;
  logic                 last_r, last_nxt;

  logic [SW-1:0]        acc_r, acc_nxt;
  logic [PW-1:0]        prod_r, prod_nxt;
  logic [DW-1:0]        dq_r, dq_nxt;
  logic [DVW-1:0]       rem_r, rem_nxt, dv_r, dv_nxt;
  logic [SW-1:0]        sq_op_r, sq_op_nxt;
  logic [RW-1:0]        sq_rem_r, sq_rem_nxt;
  logic [CW-1:0]        root_r, root_nxt;
  logic signed [XW-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [ZW-1:0] cz_r, cz_nxt;
  logic [5:0]           cnt_r, cnt_nxt;
  logic [14:0]          mag_r, mag_nxt;

  logic signed [15:0]   res_steer_r, res_steer_nxt;
  logic [13:0]          res_speed_r, res_speed_nxt;
  logic [2:0]           res_code_r, res_code_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic signed [15:0]   out_steer_r, out_steer_nxt;
  logic [13:0]          out_speed_r, out_speed_nxt;
  logic [2:0]           out_code_r, out_code_nxt;

  // ---------------------------------------------------------------------
  // handshake
  logic out_free, in_fire, tick_fire, point_fire;

  assign out_free   = !out_valid_r || out_ready;
  assign in_ready   = (state_r == pps_pkg::ST_IDLE) && out_free;
  assign in_fire    = in_valid && in_ready;
  assign tick_fire  = in_fire && in_kind;
  assign point_fire = in_fire && !in_kind;

  assign out_valid   = out_valid_r;
  assign out_steer   = out_steer_r;
  assign out_speed   = out_speed_r;
  assign out_outcome = out_code_r;

  // ---------------------------------------------------------------------
  // helper values
  logic        la_degen;
  logic [13:0] s_pick, s_clip;
  logic [CW-1:0] ax, ay, agy;

  assign la_degen = (la_max_r < la_min_r) || (spd_max_r == 14'd0);
  assign s_pick   = (spd_cmd_r >= 14'd2) ? spd_cmd_r : spd_tgt_r;
  assign s_clip   = (s_pick > spd_max_r) ? spd_max_r : s_pick;
  assign ax       = px_r[CW-1] ? CW'(-px_r) : px_r;
  assign ay       = py_r[CW-1] ? CW'(-py_r) : py_r;
  assign agy      = gy_r[CW-1] ? CW'(-gy_r) : gy_r;

  // clipped CORDIC angle
  logic [AF+1:0] ang;
  assign ang = cz_r[ZW-1] ? '0 : cz_r[AF+1:0];

  // gain product with the fraction dropped
  logic [PW-GAIN_SHIFT-1:0] gain_whole;
  assign gain_whole = prod_r[PW-1:GAIN_SHIFT];

  // shared multiplier
  logic [MW-1:0] mul_a, mul_b;
  logic [PW-1:0] mul_p;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      pps_pkg::ST_LA_MUL: begin
        mul_a = MW'(s_clip);
        mul_b = MW'(la_max_r - la_min_r);
      end
      pps_pkg::ST_SQ_X: begin
        mul_a = MW'(ax);
        mul_b = MW'(ax);
      end
      pps_pkg::ST_SQ_Y: begin
        mul_a = MW'(ay);
        mul_b = MW'(ay);
      end
      pps_pkg::ST_LA_SQ: begin
        mul_a = MW'(la_r);
        mul_b = MW'(la_r);
      end
      pps_pkg::ST_MUL_VX: begin
        mul_a = MW'(la_r);
        mul_b = MW'(root_r);
      end
      pps_pkg::ST_MUL_VY: begin
        mul_a = MW'({wb_r, 1'b0});
        mul_b = MW'(agy);
      end
      pps_pkg::ST_GAIN: begin
        mul_a = MW'(ang);
        mul_b = MW'(gain_r);
      end
      pps_pkg::ST_SPD_MUL: begin
        mul_a = MW'(spd_tgt_r);
        mul_b = MW'({max_ang_r, 1'b0} - {1'b0, mag_r});
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // divider step: one quotient bit per cycle
  logic [DVW:0]   div_sh;
  logic           div_ge;
  logic [DVW-1:0] div_rem;
  logic [DW-1:0]  div_q;

  assign div_sh  = {rem_r, dq_r[DW-1]};
  assign div_ge  = div_sh >= {1'b0, dv_r};
  assign div_rem = div_ge ? DVW'(div_sh - {1'b0, dv_r}) : DVW'(div_sh);
  assign div_q   = {dq_r[DW-2:0], div_ge};

  // square root step: one root bit per cycle
  logic [RW+1:0] sq_t, sq_trial;
  logic          sq_ge;

  assign sq_t     = {sq_rem_r, sq_op_r[SW-1:SW-2]};
  assign sq_trial = (RW+2)'({root_r, 2'b01});
  assign sq_ge    = sq_t >= sq_trial;

  // CORDIC vectoring step
  logic [31:0]          atan_raw, atan_rnd;
  logic signed [ZW-1:0] atan_a;
  logic signed [XW-1:0] cdx, cdy;
  logic                 norm_fast, norm_more;

  assign atan_raw  = pps_pkg::ATAN_Q30[cnt_r[4:0]];
  assign atan_rnd  = (atan_raw + (32'd1 << (29 - AF))) >> (30 - AF);
  assign atan_a    = ZW'(atan_rnd);
  assign cdx       = cy_r >>> cnt_r[4:0];
  assign cdy       = cx_r >>> cnt_r[4:0];
  assign norm_fast = (cx_r[XW-1:pps_pkg::NORM_FAST] == '0) &&
                     (cy_r[XW-1:pps_pkg::NORM_FAST] == '0);
  assign norm_more = (cx_r[XW-1:pps_pkg::NORM_HI_BIT] == '0) &&
                     (cy_r[XW-1:pps_pkg::NORM_HI_BIT] == '0);

  // final speed clamp
  logic [13:0] spd_q, spd_lo, spd_fin;
  assign spd_q   = dq_r[13:0];
  assign spd_lo  = (spd_q < pps_pkg::SPEED_FLOOR) ? pps_pkg::SPEED_FLOOR : spd_q;
  assign spd_fin = (spd_lo > spd_max_r) ? spd_max_r : spd_lo;

  logic goal_take;
  assign goal_take = (gstat_r != 2'd2) && (px_r >= FWD_LIMIT);

  // ---------------------------------------------------------------------
  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pps_pkg::ST_IDLE: begin
        if (point_fire) begin
          if (!in_msg_r && !la_degen) state_nxt = pps_pkg::ST_LA_MUL;
          else                        state_nxt = pps_pkg::ST_SQ_X;
        end
      end
      pps_pkg::ST_LA_MUL: state_nxt = pps_pkg::ST_LA_DIV;
      pps_pkg::ST_LA_DIV: begin
        if (cnt_r == 6'(DW - 1)) state_nxt = pps_pkg::ST_SQ_X;
      end
      pps_pkg::ST_SQ_X:   state_nxt = pps_pkg::ST_SQ_Y;
      pps_pkg::ST_SQ_Y:   state_nxt = pps_pkg::ST_LA_SQ;
      pps_pkg::ST_LA_SQ:  state_nxt = pps_pkg::ST_GOAL;
      pps_pkg::ST_GOAL:   state_nxt = last_r ? pps_pkg::ST_FINISH : pps_pkg::ST_IDLE;
      pps_pkg::ST_FINISH: begin
        priority if (pts_r < 2'd2)            state_nxt = pps_pkg::ST_OUT;
        else if (gstat_r == 2'd0)             state_nxt = pps_pkg::ST_OUT;
        else if (gmag_r <= SW'(1))            state_nxt = pps_pkg::ST_OUT;
        else                                  state_nxt = pps_pkg::ST_SQRT;
      end
      pps_pkg::ST_SQRT: begin
        if (cnt_r == 6'(CW - 1)) state_nxt = pps_pkg::ST_MUL_VX;
      end
      pps_pkg::ST_MUL_VX:    state_nxt = pps_pkg::ST_MUL_VY;
      pps_pkg::ST_MUL_VY:    state_nxt = pps_pkg::ST_NORM_INIT;
      pps_pkg::ST_NORM_INIT: begin
        state_nxt = (prod_r == '0) ? pps_pkg::ST_GAIN : pps_pkg::ST_NORM;
      end
      pps_pkg::ST_NORM: begin
        if (!norm_more) state_nxt = pps_pkg::ST_CORDIC;
      end
      pps_pkg::ST_CORDIC: begin
        if (cnt_r == 6'(CORDIC_ITERS - 1)) state_nxt = pps_pkg::ST_GAIN;
      end
      pps_pkg::ST_GAIN:    state_nxt = pps_pkg::ST_CLAMP;
      pps_pkg::ST_CLAMP:   state_nxt = pps_pkg::ST_SPD_MUL;
      pps_pkg::ST_SPD_MUL: begin
        state_nxt = (max_ang_r == 15'd0) ? pps_pkg::ST_SPD_DONE : pps_pkg::ST_SPD_DIV;
      end
      pps_pkg::ST_SPD_DIV: begin
        if (cnt_r == 6'(DW - 1)) state_nxt = pps_pkg::ST_SPD_DONE;
      end
      pps_pkg::ST_SPD_DONE: state_nxt = pps_pkg::ST_OUT;
      pps_pkg::ST_OUT: begin
        if (out_free) state_nxt = pps_pkg::ST_IDLE;
      end
      default: state_nxt = pps_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // datapath
  always_comb begin
    spd_cmd_nxt   = spd_cmd_r;
    idle_nxt      = idle_r;
    in_msg_nxt    = in_msg_r;
    pts_nxt       = pts_r;
    la_nxt        = la_r;
    gx_nxt        = gx_r;
    gy_nxt        = gy_r;
    gstat_nxt     = gstat_r;
    gmag_nxt      = gmag_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    last_nxt      = last_r;
    acc_nxt       = acc_r;
    prod_nxt      = prod_r;
    dq_nxt        = dq_r;
    rem_nxt       = rem_r;
    dv_nxt        = dv_r;
    sq_op_nxt     = sq_op_r;
    sq_rem_nxt    = sq_rem_r;
    root_nxt      = root_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    cz_nxt        = cz_r;
    cnt_nxt       = cnt_r;
    mag_nxt       = mag_r;
    res_steer_nxt = res_steer_r;
    res_speed_nxt = res_speed_r;
    res_code_nxt  = res_code_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_steer_nxt = out_steer_r;
    out_speed_nxt = out_speed_r;
    out_code_nxt  = out_code_r;

    unique case (state_r)
      pps_pkg::ST_IDLE: begin
        // timer tick: count idle time, stop once past the timeout
        if (tick_fire) begin
          if (idle_r != 8'hFF) idle_nxt = idle_r + 8'd1;
          if (idle_r >= tmo_r) begin
            spd_cmd_nxt   = '0;
            out_valid_nxt = 1'b1;
            out_steer_nxt = '0;
            out_speed_nxt = '0;
            out_code_nxt  = pps_pkg::OC_TIMEOUT;
          end
        end
        // path point: latch it, open a new path if needed
        if (point_fire) begin
          idle_nxt = '0;
          px_nxt   = in_point_x;
          py_nxt   = in_point_y;
          last_nxt = in_last_point;
          if (!in_msg_r) begin
            in_msg_nxt = 1'b1;
            pts_nxt    = 2'd1;
            gstat_nxt  = 2'd0;
            if (la_degen) la_nxt = la_min_r;
          end else if (pts_r < 2'd2) begin
            pts_nxt = pts_r + 2'd1;
          end
        end
      end
      pps_pkg::ST_LA_MUL: begin
        dq_nxt  = mul_p[DW-1:0];
        rem_nxt = '0;
        dv_nxt  = DVW'(spd_max_r);
        cnt_nxt = '0;
      end
      pps_pkg::ST_LA_DIV: begin
        dq_nxt  = div_q;
        rem_nxt = div_rem;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(DW - 1)) la_nxt = la_min_r + div_q[14:0];
      end
      pps_pkg::ST_SQ_X: prod_nxt = mul_p;
      pps_pkg::ST_SQ_Y: begin
        prod_nxt = mul_p;
        acc_nxt  = prod_r[SW-1:0];
      end
      pps_pkg::ST_LA_SQ: begin
        prod_nxt = mul_p;
        acc_nxt  = acc_r + prod_r[SW-1:0];
      end
      // update the running pick; lock it once the lookahead is reached
      pps_pkg::ST_GOAL: begin
        if (goal_take) begin
          gx_nxt    = px_r;
          gy_nxt    = py_r;
          gmag_nxt  = acc_r;
          gstat_nxt = (PW'(acc_r) >= prod_r) ? 2'd2 : 2'd1;
        end
        if (last_r) in_msg_nxt = 1'b0;
      end
      pps_pkg::ST_FINISH: begin
        res_steer_nxt = '0;
        res_speed_nxt = '0;
        sq_op_nxt     = gmag_r;
        sq_rem_nxt    = '0;
        root_nxt      = '0;
        cnt_nxt       = '0;
        priority if (pts_r < 2'd2) begin
          res_code_nxt = pps_pkg::OC_SHORT_PATH;
          spd_cmd_nxt  = '0;
        end else if (gstat_r == 2'd0) begin
          res_code_nxt = pps_pkg::OC_NO_FORWARD;
          spd_cmd_nxt  = '0;
        end else if (gmag_r <= SW'(1)) begin
          res_code_nxt = pps_pkg::OC_AT_ORIGIN;
          spd_cmd_nxt  = '0;
        end else begin
          res_code_nxt = pps_pkg::OC_DRIVE;
        end
      end
      pps_pkg::ST_SQRT: begin
        sq_rem_nxt = sq_ge ? RW'(sq_t - sq_trial) : RW'(sq_t);
        root_nxt   = {root_r[CW-2:0], sq_ge};
        sq_op_nxt  = {sq_op_r[SW-3:0], 2'b00};
        cnt_nxt    = cnt_r + 6'd1;
      end
      pps_pkg::ST_MUL_VX: prod_nxt = mul_p;
      pps_pkg::ST_MUL_VY: begin
        prod_nxt = mul_p;
        cx_nxt   = XW'(prod_r[VW-1:0]);
      end
      pps_pkg::ST_NORM_INIT: begin
        cy_nxt  = XW'(prod_r[VW-1:0]);
        cz_nxt  = '0;
        cnt_nxt = '0;
      end
      // scale both inputs up until one reaches bit 40
      pps_pkg::ST_NORM: begin
        if (norm_fast) begin
          cx_nxt = cx_r <<< 4;
          cy_nxt = cy_r <<< 4;
        end else if (norm_more) begin
          cx_nxt = cx_r <<< 1;
          cy_nxt = cy_r <<< 1;
        end
      end
      pps_pkg::ST_CORDIC: begin
        if (cy_r > 0) begin
          cx_nxt = cx_r + cdx;
          cy_nxt = cy_r - cdy;
          cz_nxt = cz_r + atan_a;
        end else begin
          cx_nxt = cx_r - cdx;
          cy_nxt = cy_r + cdy;
          cz_nxt = cz_r - atan_a;
        end
        cnt_nxt = cnt_r + 6'd1;
      end
      pps_pkg::ST_GAIN: prod_nxt = mul_p;
      pps_pkg::ST_CLAMP: begin
        mag_nxt = (gain_whole > (PW-GAIN_SHIFT)'(max_ang_r)) ? max_ang_r
                                                             : gain_whole[14:0];
      end
      // speed lowered in turns: target * (2m - |steer|) / 2m
      pps_pkg::ST_SPD_MUL: begin
        cnt_nxt = '0;
        rem_nxt = '0;
        dv_nxt  = DVW'({max_ang_r, 1'b0});
        if (max_ang_r == 15'd0) dq_nxt = DW'(spd_tgt_r);
        else                    dq_nxt = mul_p[DW-1:0];
      end
      pps_pkg::ST_SPD_DIV: begin
        dq_nxt  = div_q;
        rem_nxt = div_rem;
        cnt_nxt = cnt_r + 6'd1;
      end
      pps_pkg::ST_SPD_DONE: begin
        spd_cmd_nxt   = spd_fin;
        res_speed_nxt = spd_fin;
        res_code_nxt  = pps_pkg::OC_DRIVE;
        res_steer_nxt = gy_r[CW-1] ? (16'sd0 - $signed({1'b0, mag_r}))
                                   : $signed({1'b0, mag_r});
      end
      pps_pkg::ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_steer_nxt = res_steer_r;
          out_speed_nxt = res_speed_r;
          out_code_nxt  = res_code_r;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------
  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pps_pkg::ST_IDLE;
      spd_cmd_r   <= '0;
      idle_r      <= '0;
      in_msg_r    <= 1'b0;
      pts_r       <= '0;
      la_r        <= '0;
      gstat_r     <= '0;
      gx_r        <= '0;
      gy_r        <= '0;
      gmag_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      spd_cmd_r   <= spd_cmd_nxt;
      idle_r      <= idle_nxt;
      in_msg_r    <= in_msg_nxt;
      pts_r       <= pts_nxt;
      la_r        <= la_nxt;
      gstat_r     <= gstat_nxt;
      gx_r        <= gx_nxt;
      gy_r        <= gy_nxt;
      gmag_r      <= gmag_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    px_r        <= px_nxt;
    py_r        <= py_nxt;
    last_r      <= last_nxt;
    acc_r       <= acc_nxt;
    prod_r      <= prod_nxt;
    dq_r        <= dq_nxt;
    rem_r       <= rem_nxt;
    dv_r        <= dv_nxt;
    sq_op_r     <= sq_op_nxt;
    sq_rem_r    <= sq_rem_nxt;
    root_r      <= root_nxt;
    cx_r        <= cx_nxt;
    cy_r        <= cy_nxt;
    cz_r        <= cz_nxt;
    mag_r       <= mag_nxt;
    res_steer_r <= res_steer_nxt;
    res_speed_r <= res_speed_nxt;
    res_code_r  <= res_code_nxt;
    out_steer_r <= out_steer_nxt;
    out_speed_r <= out_speed_nxt;
    out_code_r  <= out_code_nxt;
  end

endmodule

`default_nettype wire

@@ dv/pps_steering_checker.sv @@
`default_nettype none

module pps_steering_checker (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire logic               in_kind,
  input  wire logic signed [17:0] in_point_x,
  input  wire logic signed [17:0] in_point_y,
  input  wire logic               in_last_point,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire logic signed [15:0] out_steer,
  input  wire logic [13:0]        out_speed,
  input  wire logic [2:0]         out_outcome,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  output int                      fail_count,
  output int                      pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [15:0] steer;
    logic [13:0]        speed;
    pps_pkg::outcome_t  outcome;
  } command_t;

  command_t cmd_queue[$];

  // register copy
  longint unsigned la_min, la_max, spd_tgt, spd_max, wbase, gain, max_ang, tmo;
  // path and speed state
  longint unsigned spd_cmd, idle_cnt, pts_seen, la_now, goal_state;
  bit              collecting;
  longint          goal_px, goal_py;

  assign pending_count = cmd_queue.size();

  function automatic longint unsigned sq_dist(longint px, longint py);
    longint unsigned ax, ay;
    ax = (px < 0) ? -px : px;
    ay = (py < 0) ? -py : py;
    return ax * ax + ay * ay;
  endfunction

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // vectoring angle in [0, pi/2], 2^-14 rad
  function automatic longint vector_angle(longint unsigned vx, longint unsigned vy);
    longint cx, cy, z, a, dx, dy;
    z = 0;
    if (vy == 0) return 0;
    while (vx < (64'd1 << 40) && vy < (64'd1 << 40)) begin
      vx <<= 1;
      vy <<= 1;
    end
    cx = vx;
    cy = vy;
    for (int i = 0; i < 16; i++) begin
      a = (longint'(pps_pkg::ATAN_Q30[i]) + (64'sd1 << 15)) >>> 16;
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy > 0) begin
        cx += dx; cy -= dy; z += a;
      end else begin
        cx -= dx; cy += dy; z -= a;
      end
    end
    return (z < 0) ? 0 : z;
  endfunction

  function automatic longint unsigned adapt_lookahead();
    longint unsigned s;
    if (la_max < la_min || spd_max == 0) return la_min;
    s = (spd_cmd >= 2) ? spd_cmd : spd_tgt;
    if (s > spd_max) s = spd_max;
    return la_min + s * (la_max - la_min) / spd_max;
  endfunction

  function automatic command_t stop_cmd(pps_pkg::outcome_t oc);
    command_t c;
    spd_cmd = 0;
    c.steer = '0;
    c.speed = '0;
    c.outcome = oc;
    return c;
  endfunction

  function automatic command_t steer_toward_goal();
    longint unsigned r, ay, ang, mag, spd;
    command_t c;
    if (pts_seen < 2) return stop_cmd(pps_pkg::OC_SHORT_PATH);
    if (goal_state == 0) return stop_cmd(pps_pkg::OC_NO_FORWARD);
    if (sq_dist(goal_px, goal_py) <= 1) return stop_cmd(pps_pkg::OC_AT_ORIGIN);
    r = int_root(sq_dist(goal_px, goal_py));
    ay = (goal_py < 0) ? -goal_py : goal_py;
    ang = vector_angle(la_now * r, 2 * wbase * ay);
    mag = (ang * gain) >> 12;
    if (mag > max_ang) mag = max_ang;
    if (max_ang == 0) spd = spd_tgt;
    else spd = spd_tgt * (2 * max_ang - mag) / (2 * max_ang);
    if (spd < 307) spd = 307;
    if (spd > spd_max) spd = spd_max;
    spd_cmd = spd;
    c.steer = (goal_py < 0) ? -16'(mag) : 16'(mag);
    c.speed = spd[13:0];
    c.outcome = pps_pkg::OC_DRIVE;
    return c;
  endfunction

  task automatic predict_request(bit kind, longint px, longint py, bit last);
    longint unsigned prior;
    if (kind) begin
      prior = idle_cnt;
      if (idle_cnt < 255) idle_cnt++;
      if (prior >= tmo) cmd_queue.push_back(stop_cmd(pps_pkg::OC_TIMEOUT));
      return;
    end
    idle_cnt = 0;
    if (!collecting) begin
      collecting = 1;
      pts_seen = 0;
      goal_state = 0;
      la_now = adapt_lookahead();
    end
    if (pts_seen < 2) pts_seen++;
    if (goal_state != 2 && px >= -51) begin
      goal_px = px;
      goal_py = py;
      goal_state = (sq_dist(px, py) >= la_now * la_now) ? 2 : 1;
    end
    if (last) begin
      collecting = 0;
      cmd_queue.push_back(steer_toward_goal());
    end
  endtask

  always @(posedge clk) begin
    command_t got, want;
    if (!rst_n) begin
      la_min = 819; la_max = 3072; spd_tgt = 1536; spd_max = 3072;
      wbase = 328; gain = 4096; max_ang = 6554; tmo = 5;
      spd_cmd = 0; idle_cnt = 0; collecting = 0; pts_seen = 0;
      la_now = 0; goal_px = 0; goal_py = 0; goal_state = 0;
      cmd_queue.delete();
    end else begin
      if (cfg_we) begin
        case (pps_pkg::cfg_idx_t'(cfg_index))
          pps_pkg::CFG_LA_MIN:    la_min = cfg_data[14:0];
          pps_pkg::CFG_LA_MAX:    la_max = cfg_data[14:0];
          pps_pkg::CFG_SPD_TGT:   spd_tgt = cfg_data[13:0];
          pps_pkg::CFG_SPD_MAX:   spd_max = cfg_data[13:0];
          pps_pkg::CFG_WHEELBASE: wbase = cfg_data[12:0];
          pps_pkg::CFG_GAIN:      gain = cfg_data;
          pps_pkg::CFG_MAX_ANGLE: max_ang = cfg_data[14:0];
          pps_pkg::CFG_TIMEOUT:   tmo = cfg_data[7:0];
          default: ;
        endcase
      end
      // compare the result first, then predict the new request
      if (out_valid && out_ready) begin
        got.steer = out_steer;
        got.speed = out_speed;
        got.outcome = pps_pkg::outcome_t'(out_outcome);
        if (cmd_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result steer=%0d speed=%0d outcome=%0d",
                     got.steer, got.speed, got.outcome);
        end else begin
          want = cmd_queue.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: exp steer=%0d speed=%0d outcome=%0d, got %0d %0d %0d",
                       want.steer, want.speed, want.outcome,
                       got.steer, got.speed, got.outcome);
          end
        end
      end
      if (in_valid && in_ready)
        predict_request(in_kind, in_point_x, in_point_y, in_last_point);
    end
  end

  initial fail_count = 0;

endmodule

`default_nettype wire

@@ dv/tb_pure_pursuit_steering_unit.sv @@
`default_nettype none

module tb_pure_pursuit_steering_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1500000;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_ready;
  logic               in_kind = 0;
  logic signed [17:0] in_point_x = '0;
  logic signed [17:0] in_point_y = '0;
  logic               in_last_point = 0;
  logic               out_valid;
  logic               out_ready = 0;
  logic signed [15:0] out_steer;
  logic [13:0]        out_speed;
  logic [2:0]         out_outcome;
  logic               cfg_we = 0;
  logic [2:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;
  int                 fail_count, pending_count;
  int                 sender_idle_pct = 0, recv_stall_pct = 0;
  bit                 hold_off = 0;
  int                 cycles = 0;

  always #5 clk = ~clk;

  pure_pursuit_steering_unit uut (.*);

  pps_steering_checker chk (.*);

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_off) out_ready <= 0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_pure_pursuit_steering_unit: FAIL");
      $finish;
    end
  end

  // valid stays up between back-to-back requests; idle cycles and drain drop it
  task automatic send_request(bit kind, logic signed [17:0] px, logic signed [17:0] py,
                              bit last);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_kind <= kind;
    in_point_x <= px;
    in_point_y <= py;
    in_last_point <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending_count != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_reg(pps_pkg::cfg_idx_t idx, int unsigned val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val[15:0];
    @(negedge clk);
    cfg_we <= 0;
    @(negedge clk);
  endtask

  function automatic logic signed [17:0] rand_coord();
    case ($urandom_range(5))
      0: return 18'($urandom);
      1: return 18'($urandom_range(8000) - 4000);
      2: return 18'($urandom_range(3) - 1);
      3: return 18'(-51 - int'($urandom_range(1)));
      default: return 18'($urandom_range(6000) - 200);
    endcase
  endfunction

  // a well-formed path of n points with random content
  task automatic send_path(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(15) == 0)
        send_request(1, 18'($urandom), 18'($urandom), 1'($urandom));
      send_request(0, rand_coord(), rand_coord(), i == n - 1);
    end
  endtask

  task automatic random_config(bit extreme);
    write_reg(pps_pkg::CFG_LA_MIN,
              extreme ? ($urandom_range(1) ? 32767 : 0) : $urandom_range(3000));
    write_reg(pps_pkg::CFG_LA_MAX,
              extreme ? ($urandom_range(1) ? 32767 : 0) : $urandom_range(6000));
    write_reg(pps_pkg::CFG_SPD_TGT,
              extreme ? ($urandom_range(1) ? 16383 : 0) : $urandom_range(5000));
    write_reg(pps_pkg::CFG_SPD_MAX, extreme ? ($urandom_range(1) ? 16383 : 307)
                                            : $urandom_range(6000, 307));
    write_reg(pps_pkg::CFG_WHEELBASE,
              extreme ? ($urandom_range(1) ? 8191 : 1) : $urandom_range(1000, 1));
    write_reg(pps_pkg::CFG_GAIN,
              extreme ? ($urandom_range(1) ? 65535 : 0) : $urandom_range(12000));
    write_reg(pps_pkg::CFG_MAX_ANGLE, extreme ? ($urandom_range(1) ? 25736 : 1)
                                              : $urandom_range(25736, 1));
    write_reg(pps_pkg::CFG_TIMEOUT,
              extreme ? ($urandom_range(1) ? 255 : 1) : $urandom_range(10, 1));
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: field extremes, stops of every kind, ticks
    send_request(0, 18'sd1000, 18'sd0, 1);                 // short path
    send_request(0, -18'sd52, 18'sd5, 0);
    send_request(0, -18'sd131072, 18'sd131071, 1);         // no forward point
    send_request(0, -18'sd51, 18'sd0, 0);
    send_request(0, 18'sd1, 18'sd0, 1);                    // goal at origin
    send_request(0, 18'sd131071, -18'sd131072, 0);
    send_request(0, 18'sd500, 18'sd400, 1);
    send_request(0, 18'sd200, -18'sd100, 0);
    send_request(1, 18'sd0, 18'sd0, 0);                    // tick inside a path
    send_request(0, 18'sd3000, 18'sd2000, 1);
    for (int i = 0; i < 8; i++)
      send_request(1, 18'($urandom), 18'($urandom), 1'($urandom));
    send_request(0, 18'sd100, -18'sd131072, 0);
    send_request(0, 18'sd131071, 18'sd131071, 1);
    drain();

    // max below min, smallest nonzero angle limit, speed limit at the floor, timeout of one
    write_reg(pps_pkg::CFG_LA_MIN, 2000);
    write_reg(pps_pkg::CFG_LA_MAX, 100);
    write_reg(pps_pkg::CFG_MAX_ANGLE, 1);
    write_reg(pps_pkg::CFG_SPD_MAX, 307);
    write_reg(pps_pkg::CFG_TIMEOUT, 1);
    send_path(3);
    send_request(1, 18'sd0, 18'sd0, 0);
    send_request(1, 18'sd0, 18'sd0, 0);
    drain();

    // random phases across idle settings and configurations
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin sender_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      random_config(ph == 3 || ph == 6);
      if (ph == 2) begin
        // long receiver hold-off while requests keep coming
        fork
          begin
            hold_off = 1;
            repeat (2000) @(negedge clk);
            hold_off = 0;
          end
          repeat (3) send_path(6);
        join
      end
      for (int k = 0; k < 40; k++) begin
        if ($urandom_range(9) == 0)
          send_request(1, 18'($urandom), 18'($urandom), 1'($urandom));
        else if ($urandom_range(19) == 0) send_request(0, rand_coord(), rand_coord(), 1);
        else send_path($urandom_range(6, 2));
      end
      // sender waits for every result before the next phase
      drain();
    end

    sender_idle_pct = 0;
    recv_stall_pct = 0;
    drain();
    if (fail_count == 0) $display("tb_pure_pursuit_steering_unit: PASS");
    else $display("tb_pure_pursuit_steering_unit: FAIL");
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
sv/pps_pkg.sv
sv/pure_pursuit_steering_unit.sv
dv/pps_steering_checker.sv
dv/tb_pure_pursuit_steering_unit.sv
